// ===== hdl/region_adjacency_builder_macros.svh =====
// Assertion macros shared by the region adjacency builder modules.
// Depends on nothing; users must have signals named clock and reset in scope.
`ifndef REGION_ADJACENCY_BUILDER_MACROS_SVH
`define REGION_ADJACENCY_BUILDER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RAB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RAB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rab_pkg.sv =====
// Shared constants, codes and control structs for the region adjacency builder.
// Depends on nothing; used by rab_ctrl, rab_dp and region_adjacency_builder.
`default_nettype none

package rab_pkg;

   // Default sizes of the adjacency and line stores.
   localparam int MAX_REGIONS_DEF = 256;
   localparam int MAX_WIDTH_DEF   = 1024;

   // Fixed field widths.
   localparam int CMD_W     = 2;
   localparam int LABEL_W   = 9;
   localparam int IMG_W_W   = 11;
   localparam int RCOUNT_W  = 9;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 11;

   // Command codes of an input beat.
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PIXEL  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_COUNT = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic clr_start;
      logic clr_step;
      logic pix_a;
      logic pix_b;
      logic qry_a;
      logic emit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_done;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hdl/region_adjacency_builder.sv =====
// Sequencing: a pixel beat reads the line store and marks the pair with its left neighbor,
// then marks the pair with the pixel above and writes the line store; a query beat reads
// the adjacency row, then presents its result; a clear runs a clearing pass over both stores.
// A new beat is taken only back in idle, once the last result is loaded; a held result stalls.
// Reset: synchronous; a clearing pass follows, with req_ready low; configuration writes are
// taken throughout.
`default_nettype none

module region_adjacency_builder #(
   parameter int MAX_REGIONS = rab_pkg::MAX_REGIONS_DEF,
   parameter int MAX_WIDTH   = rab_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [rab_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic [rab_pkg::LABEL_W-1:0]    req_pixel_label,
   input  wire logic [rab_pkg::LABEL_W-1:0]    req_query_first,
   input  wire logic [rab_pkg::LABEL_W-1:0]    req_query_second,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_adjacent,
   output logic                                rsp_bad_label,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [rab_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rab_pkg::CSR_DAT_W-1:0]  csr_wdata
);

   rab_pkg::ctrl_cmd_type  ctl;
   rab_pkg::dp_status_type status;

   // Configuration beats are always taken.
   assign csr_ready = 1'b1;

   rab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .ctl       (ctl)
   );

   rab_dp #(
      .MAX_REGIONS (MAX_REGIONS),
      .MAX_WIDTH   (MAX_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .status           (status),
      .req_cmd          (req_cmd),
      .req_pixel_label  (req_pixel_label),
      .req_query_first  (req_query_first),
      .req_query_second (req_query_second),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_adjacent     (rsp_adjacent),
      .rsp_bad_label    (rsp_bad_label)
   );

endmodule

`default_nettype wire

// ===== hdl/rab_ctrl.sv =====
// Controller state machine of the region adjacency builder: handshakes and sequencing.
// Depends on rab_pkg and region_adjacency_builder_macros.svh.
`default_nettype none
`include "region_adjacency_builder_macros.svh"

module rab_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [rab_pkg::CMD_W-1:0] req_cmd,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire rab_pkg::dp_status_type    status,
   output rab_pkg::ctrl_cmd_type          ctl
);

   typedef enum logic [7:0] {
      ST_INIT  = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_CLEAR = 8'b0000_0100,
      ST_PIX_A = 8'b0000_1000,
      ST_PIX_B = 8'b0001_0000,
      ST_QRY_A = 8'b0010_0000,
      ST_QRY_B = 8'b0100_0000,
      ST_RESP  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   // New beats are taken only when no item is in flight.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_INIT: begin
            ctl.clr_step = 1'b1;
            if (status.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               ctl.capture = 1'b1;
               case (req_cmd)
                  rab_pkg::CMD_CLEAR: begin
                     ctl.clr_start = 1'b1;
                     state_in      = ST_CLEAR;
                  end
                  rab_pkg::CMD_PIXEL: state_in = ST_PIX_A;
                  rab_pkg::CMD_QUERY: state_in = ST_QRY_A;
                  default:            state_in = ST_RESP;
               endcase
            end
         end
         ST_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (status.clr_done) begin
               state_in = ST_RESP;
            end
         end
         ST_PIX_A: begin
            ctl.pix_a = 1'b1;
            state_in  = ST_PIX_B;
         end
         ST_PIX_B: begin
            ctl.pix_b = 1'b1;
            ctl.emit  = slot_free;
            state_in  = slot_free ? ST_IDLE : ST_RESP;
         end
         ST_QRY_A: begin
            ctl.qry_a = 1'b1;
            state_in  = ST_QRY_B;
         end
         ST_QRY_B: begin
            ctl.emit = slot_free;
            state_in = slot_free ? ST_IDLE : ST_RESP;
         end
         ST_RESP: begin
            ctl.emit = slot_free;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Result valid flag of the output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result is never loaded over one that has not been taken.
   `RAB_ASSERT_NOW(a_emit_slot_free, ctl.emit, !rsp_valid_ff || rsp_ready, "result overwritten")
   // A pixel beat always starts the pixel sequence.
   `RAB_ASSERT_NEXT(a_pixel_start, accept && req_cmd == rab_pkg::CMD_PIXEL, state_ff == ST_PIX_A, "pixel not started")
   // The end of a clearing pass for a clear command leads to its result.
   `RAB_ASSERT_NEXT(a_clear_end, state_ff == ST_CLEAR && status.clr_done, state_ff == ST_RESP, "clear result lost")

endmodule

`default_nettype wire

// ===== hdl/rab_dp.sv =====
// Datapath of the region adjacency builder: config registers, line store,
// adjacency bit store, frame position and the result register. Depends on rab_pkg and the macros.
`default_nettype none
`include "region_adjacency_builder_macros.svh"

module rab_dp #(
   parameter int MAX_REGIONS = rab_pkg::MAX_REGIONS_DEF,
   parameter int MAX_WIDTH   = rab_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rab_pkg::ctrl_cmd_type          ctl,
   output rab_pkg::dp_status_type              status,
   input  wire logic [rab_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic [rab_pkg::LABEL_W-1:0]    req_pixel_label,
   input  wire logic [rab_pkg::LABEL_W-1:0]    req_query_first,
   input  wire logic [rab_pkg::LABEL_W-1:0]    req_query_second,
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic [rab_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rab_pkg::CSR_DAT_W-1:0]  csr_wdata,
   output logic                                rsp_adjacent,
   output logic                                rsp_bad_label
);

   localparam int RW        = $clog2(MAX_REGIONS);
   localparam int RCW       = (RW + 1 > rab_pkg::LABEL_W) ? RW + 1 : rab_pkg::LABEL_W;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int EW        = (COL_W + 1 > rab_pkg::IMG_W_W) ? COL_W + 1 : rab_pkg::IMG_W_W;
   localparam int CLR_DEPTH = (MAX_REGIONS > MAX_WIDTH) ? MAX_REGIONS : MAX_WIDTH;
   localparam int CLW       = $clog2(CLR_DEPTH);
   localparam int LINE_W    = RW + 1;

   // Label check against the effective region count.
   function automatic logic lab_ok(input logic [rab_pkg::LABEL_W-1:0] lab,
                                   input logic [RCW-1:0] lim);
      return (lab != '0) && (RCW'(lab) <= lim);
   endfunction

   // Zero-based region index of a label.
   function automatic logic [RW-1:0] lab_idx(input logic [rab_pkg::LABEL_W-1:0] lab);
      logic [RCW-1:0] m;
      m = RCW'(lab) - RCW'(1);
      return m[RW-1:0];
   endfunction

   // Configuration registers.
   logic [rab_pkg::IMG_W_W-1:0]  img_width_ff;
   logic [rab_pkg::RCOUNT_W-1:0] reg_count_ff;

   // Captured item.
   logic [rab_pkg::CMD_W-1:0]   item_cmd_ff;
   logic [rab_pkg::LABEL_W-1:0] item_pix_ff;
   logic [rab_pkg::LABEL_W-1:0] item_qa_ff;
   logic [rab_pkg::LABEL_W-1:0] item_qb_ff;

   // Frame position and left neighbor.
   logic [COL_W-1:0] col_ff, col_in;
   logic             past_row_ff;
   logic [RW-1:0]    left_label_ff;
   logic             left_valid_ff;

   // Clearing pass counter.
   logic [CLW-1:0] clr_cnt_ff;

   // Stores and their registered read data.
   logic [LINE_W-1:0]      line_mem [MAX_WIDTH];
   logic [LINE_W-1:0]      line_q_ff;
   logic [MAX_REGIONS-1:0] adj_mem [MAX_REGIONS];
   logic [MAX_REGIONS-1:0] adj_q_ff;

   // Combinational values.
   logic [RCW-1:0]    rc_ext, eff_rc;
   logic [EW-1:0]     img_ext, eff_w, col_next;
   logic              pix_ok;
   logic [RW-1:0]     pix_idx;
   logic              q_ok;
   logic [RW-1:0]     qa_idx, qb_idx, q_lo, q_hi;
   logic              res_adj, res_bad;
   logic [RW-1:0]     pair_other;
   logic              pair_set;
   logic              adj_clr, adj_set;
   logic [RW-1:0]     adj_wrow, adj_wcol;
   logic              ln_we;
   logic [COL_W-1:0]  ln_waddr;
   logic [LINE_W-1:0] ln_wdata;

   // Effective region count and image width.
   always_comb begin
      rc_ext  = RCW'(reg_count_ff);
      eff_rc  = (rc_ext > RCW'(MAX_REGIONS)) ? RCW'(MAX_REGIONS) : rc_ext;
      img_ext = EW'(img_width_ff);
      if (img_ext == '0) begin
         eff_w = EW'(1);
      end else if (img_ext > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = img_ext;
      end
      col_next = EW'(col_ff) + EW'(1);
   end

   // Label checks and query ordering.
   always_comb begin
      pix_ok  = lab_ok(item_pix_ff, eff_rc);
      pix_idx = pix_ok ? lab_idx(item_pix_ff) : '0;
      q_ok    = lab_ok(item_qa_ff, eff_rc) && lab_ok(item_qb_ff, eff_rc);
      qa_idx  = lab_idx(item_qa_ff);
      qb_idx  = lab_idx(item_qb_ff);
      q_lo    = (qa_idx < qb_idx) ? qa_idx : qb_idx;
      q_hi    = (qa_idx < qb_idx) ? qb_idx : qa_idx;
   end

   // Result of the captured item.
   always_comb begin
      res_adj = 1'b0;
      res_bad = 1'b0;
      case (item_cmd_ff)
         rab_pkg::CMD_PIXEL: res_bad = !pix_ok;
         rab_pkg::CMD_QUERY: begin
            res_bad = !q_ok;
            res_adj = q_ok && (qa_idx != qb_idx) && adj_q_ff[q_hi];
         end
         default: begin
            res_adj = 1'b0;
            res_bad = 1'b0;
         end
      endcase
   end

   // Pair marking: left neighbor in the first step, pixel above in the second.
   // Pairs are stored once, with the lower index as the row.
   always_comb begin
      pair_other = ctl.pix_b ? line_q_ff[RW-1:0] : left_label_ff;
      pair_set   = 1'b0;
      if (ctl.pix_a) begin
         pair_set = pix_ok && (col_ff != '0) && left_valid_ff;
      end else if (ctl.pix_b) begin
         pair_set = pix_ok && past_row_ff && line_q_ff[RW];
      end
      pair_set = pair_set && (pair_other != pix_idx);
   end

   // Write port of the adjacency store.
   always_comb begin
      adj_clr  = ctl.clr_step && ({1'b0, clr_cnt_ff} < (CLW + 1)'(MAX_REGIONS));
      adj_set  = !ctl.clr_step && pair_set;
      if (ctl.clr_step) begin
         adj_wrow = clr_cnt_ff[RW-1:0];
         adj_wcol = '0;
      end else begin
         adj_wrow = (pix_idx < pair_other) ? pix_idx : pair_other;
         adj_wcol = (pix_idx < pair_other) ? pair_other : pix_idx;
      end
   end

   // Write port of the line store.
   always_comb begin
      if (ctl.clr_step) begin
         ln_we    = ({1'b0, clr_cnt_ff} < (CLW + 1)'(MAX_WIDTH));
         ln_waddr = clr_cnt_ff[COL_W-1:0];
         ln_wdata = '0;
      end else begin
         ln_we    = ctl.pix_b;
         ln_waddr = col_ff;
         ln_wdata = {pix_ok, pix_idx};
      end
   end

   // Column wraps at the effective width.
   assign col_in = (col_next >= eff_w) ? '0 : col_next[COL_W-1:0];

   assign status.clr_done = (clr_cnt_ff == CLW'(CLR_DEPTH - 1));

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff <= rab_pkg::IMG_W_W'(1024);
         reg_count_ff <= rab_pkg::RCOUNT_W'(256);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rab_pkg::CSR_IMAGE_WIDTH:  img_width_ff <= csr_wdata;
            rab_pkg::CSR_REGION_COUNT: reg_count_ff <= csr_wdata[rab_pkg::RCOUNT_W-1:0];
            default:                   img_width_ff <= img_width_ff;
         endcase
      end
   end

   // Frame position, left neighbor and clearing counter.
   always_ff @(posedge clock) begin
      if (reset || ctl.clr_start) begin
         col_ff        <= '0;
         past_row_ff   <= 1'b0;
         left_valid_ff <= 1'b0;
         left_label_ff <= '0;
         clr_cnt_ff    <= '0;
      end else begin
         if (ctl.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + CLW'(1);
         end
         if (ctl.pix_b) begin
            left_label_ff <= pix_idx;
            left_valid_ff <= pix_ok;
            col_ff        <= col_in;
            if (col_next >= eff_w) begin
               past_row_ff <= 1'b1;
            end
         end
      end
   end

   // Captured beat and result register.
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         item_cmd_ff <= req_cmd;
         item_pix_ff <= req_pixel_label;
         item_qa_ff  <= req_query_first;
         item_qb_ff  <= req_query_second;
      end
      if (ctl.emit) begin
         rsp_adjacent  <= res_adj;
         rsp_bad_label <= res_bad;
      end
   end

   // Line store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (ln_we) begin
         line_mem[ln_waddr] <= ln_wdata;
      end
      if (ctl.pix_a) begin
         line_q_ff <= line_mem[col_ff];
      end
   end

   // Adjacency store: row clear or single bit set, and a registered row read.
   always_ff @(posedge clock) begin
      if (adj_clr) begin
         adj_mem[adj_wrow] <= '0;
      end else if (adj_set) begin
         adj_mem[adj_wrow][adj_wcol] <= 1'b1;
      end
      if (ctl.qry_a) begin
         adj_q_ff <= adj_mem[q_lo];
      end
   end

   // Pairs are kept in upper triangle form and never on the diagonal.
   `RAB_ASSERT_NOW(a_pair_order, adj_set, adj_wrow < adj_wcol, "pair stored out of order")
   // Only a query can report adjacency.
   `RAB_ASSERT_NOW(a_adj_query_only, ctl.emit && res_adj, item_cmd_ff == rab_pkg::CMD_QUERY, "adjacency on non-query")
   // A pixel's line store entry is valid exactly when the pixel is not flagged bad.
   `RAB_ASSERT_NOW(a_line_valid, ctl.pix_b, ln_wdata[RW] == !res_bad, "line entry validity mismatch")

endmodule

`default_nettype wire
